>>> hw/rtl/lepb_pkg.sv
// Shared types, constants and helper functions of the LED engine program builder.
package lepb_pkg;

	// Kind of program carried from the front end to the word emitter.
	typedef enum logic [1:0] {
		KIND_RAMP   = 2'd0,
		KIND_BLINK  = 2'd1,
		KIND_REJECT = 2'd2
	} prog_kind_t;

	// Front end sequencer states.
	typedef enum logic {
		FRONT_IDLE = 1'b0,
		FRONT_DIV  = 1'b1
	} front_state_t;

	// One program as it travels through the queue.
	typedef struct packed {
		prog_kind_t  kind;
		logic [7:0]  level;
		logic [15:0] word1;
		logic [15:0] word3;
	} prog_rec_t;

	// Instruction encodings.
	localparam logic [15:0] OP_SET_PWM  = 16'h4000;
	localparam logic [15:0] OP_LOOP     = 16'hA081;
	localparam logic [15:0] OP_END      = 16'hC000;
	localparam logic [15:0] OP_GO_START = 16'h0000;
	localparam logic [15:0] STEP_MAX    = 16'h003F;

	// Divider shape: an 18-bit dividend retired three bits per cycle.
	localparam int DIV_BITS  = 3;
	localparam int DIV_STEPS = 6;

	// Word index codes.
	localparam logic [2:0] IDX_LAST_REJECT = 3'd0;
	localparam logic [2:0] IDX_LAST_RAMP   = 3'd3;
	localparam logic [2:0] IDX_LAST_BLINK  = 3'd4;

	// Turns a raw 16-bit step time into {prescale, step[5:0]}.
	function automatic logic [6:0] scale_step(input logic [15:0] raw);
		logic [15:0] v;
		logic        pre;
		logic [5:0]  t;
		v = raw;
		pre = 1'b0;
		if (v > STEP_MAX) begin
			v = v >> 5;
			pre = 1'b1;
		end
		if (v == 16'd0) begin
			t = 6'd1;
		end else if (v > STEP_MAX) begin
			t = 6'd63;
		end else begin
			t = v[5:0];
		end
		return {pre, t};
	endfunction

	// Builds a delay instruction word from a raw step time.
	function automatic logic [15:0] delay_word(input logic [15:0] raw);
		logic [6:0] s;
		s = scale_step(raw);
		return {1'b0, s[6], s[5:0], 8'h00};
	endfunction

endpackage

>>> hw/rtl/lepb_front.sv
// Front end: accepts requests, runs the ramp divider and builds program records.
module lepb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               mode,
	input  logic [7:0]         start_level,
	input  logic [7:0]         end_level,
	input  logic [15:0]        ramp_time,
	input  logic [15:0]        on_time,
	input  logic [15:0]        period,
	input  logic [7:0]         brightness,
	output logic               rec_valid,
	output lepb_pkg::prog_rec_t rec,
	input  logic               rec_ready
);
	import lepb_pkg::*;

	front_state_t state_q, state_d;
	prog_rec_t    hold_q;
	logic         hold_valid_q;
	logic [7:0]   rem_q, rem_d;
	logic [17:0]  dvd_q, dvd_d;
	logic [17:0]  quo_q, quo_d;
	logic [2:0]   cnt_q;
	logic [7:0]   diff_q;
	logic         down_q;
	logic         accept;
	logic         div_done;
	logic         drain;
	logic         down_in;
	logic [7:0]   diff_in;
	logic [15:0]  off_time;
	logic [6:0]   ramp_scale;

	// The hold register drains into the queue whenever the queue has room.
	assign drain     = hold_valid_q && rec_ready;
	assign full      = (state_q == FRONT_DIV) || (hold_valid_q && !rec_ready);
	assign accept    = push && !full;
	assign rec_valid = hold_valid_q;
	assign rec       = hold_q;

	// Request classification.
	assign down_in  = end_level < start_level;
	assign diff_in  = down_in ? (start_level - end_level) : (end_level - start_level);
	assign off_time = period - on_time;

	// Three restoring division steps per cycle.
	always_comb begin
		logic [8:0] r;
		logic [7:0] rm;
		logic [17:0] dv;
		logic [DIV_BITS-1:0] qb;
		rm = rem_q;
		dv = dvd_q;
		qb = '0;
		for (int j = 0; j < DIV_BITS; j++) begin
			r = {rm, dv[17]};
			dv = {dv[16:0], 1'b0};
			if (r >= {1'b0, diff_q}) begin
				r = r - {1'b0, diff_q};
				qb[DIV_BITS-1-j] = 1'b1;
			end
			rm = r[7:0];
		end
		rem_d = rm;
		dvd_d = dv;
		quo_d = {quo_q[17-DIV_BITS:0], qb};
	end

	assign ramp_scale = scale_step(quo_d[15:0]);
	assign div_done   = (state_q == FRONT_DIV) && (cnt_q == 3'(DIV_STEPS - 1));

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FRONT_IDLE: begin
				if (accept && !mode && (start_level != end_level)) begin
					state_d = FRONT_DIV;
				end
			end
			FRONT_DIV: begin
				if (div_done) begin
					state_d = FRONT_IDLE;
				end
			end
			default: state_d = FRONT_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRONT_IDLE;
			hold_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == FRONT_DIV) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (div_done || (accept && (mode || (start_level == end_level)))) begin
				hold_valid_q <= 1'b1;
			end else if (drain) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	// Divider datapath and record payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q  <= '0;
			dvd_q  <= {1'b0, ramp_time, 1'b0};
			quo_q  <= '0;
			diff_q <= diff_in;
			down_q <= down_in;
			hold_q.word3 <= delay_word({off_time[14:0], 1'b0});
			hold_q.word1 <= delay_word({on_time[14:0], 1'b0});
			if (mode) begin
				hold_q.kind  <= KIND_BLINK;
				hold_q.level <= brightness;
			end else if (start_level == end_level) begin
				hold_q.kind  <= KIND_REJECT;
				hold_q.level <= start_level;
			end else begin
				hold_q.kind  <= KIND_RAMP;
				hold_q.level <= start_level;
			end
		end else if (state_q == FRONT_DIV) begin
			rem_q <= rem_d;
			dvd_q <= dvd_d;
			quo_q <= quo_d;
			if (div_done) begin
				hold_q.word1 <= {1'b0, ramp_scale[6], ramp_scale[5:0], down_q, diff_q[7:1]};
			end
		end
	end

endmodule

>>> hw/rtl/lepb_queue.sv
// Small first-in first-out queue of program records between front and back end.
module lepb_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  lepb_pkg::prog_rec_t wr_rec,
	output logic                wr_ready,
	input  logic                rd_en,
	output lepb_pkg::prog_rec_t rd_rec,
	output logic                rd_valid
);
	import lepb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	prog_rec_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign wr_ready = count_q != CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_en && rd_valid;
	assign rd_rec   = mem_q[rd_ptr_q];

	// Pointer and fill tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Record storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

>>> hw/rtl/lepb_back.sv
// Back end: walks a program record and presents its instruction words one at a time.
module lepb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	input  lepb_pkg::prog_rec_t rec,
	output logic                rec_take,
	output logic                empty,
	input  logic                pop,
	output logic [15:0]         program_word,
	output logic [2:0]          word_index,
	output logic                last,
	output logic                rejected
);
	import lepb_pkg::*;

	prog_rec_t   cur_q;
	logic        cur_valid_q;
	logic [2:0]  idx_q;
	logic [2:0]  last_idx;
	logic        word_done;

	// Index of the final word for the current program.
	always_comb begin
		case (cur_q.kind)
			KIND_RAMP:   last_idx = IDX_LAST_RAMP;
			KIND_BLINK:  last_idx = IDX_LAST_BLINK;
			KIND_REJECT: last_idx = IDX_LAST_REJECT;
			default:     last_idx = IDX_LAST_REJECT;
		endcase
	end

	assign empty      = !cur_valid_q;
	assign last       = idx_q == last_idx;
	assign word_index = idx_q;
	assign rejected   = cur_q.kind == KIND_REJECT;
	assign word_done  = pop && cur_valid_q;
	assign rec_take   = !cur_valid_q || (word_done && last);

	// Word selection by position in the program.
	always_comb begin
		program_word = OP_GO_START;
		case (idx_q)
			3'd0: program_word = (cur_q.kind == KIND_REJECT) ? 16'h0000
				: (OP_SET_PWM | {8'h00, cur_q.level});
			3'd1: program_word = cur_q.word1;
			3'd2: program_word = (cur_q.kind == KIND_RAMP) ? OP_LOOP : OP_SET_PWM;
			3'd3: program_word = (cur_q.kind == KIND_RAMP) ? OP_END : cur_q.word3;
			3'd4: program_word = OP_GO_START;
			default: program_word = OP_GO_START;
		endcase
	end

	// Current program and word position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (rec_take) begin
				cur_valid_q <= rec_valid;
				idx_q <= '0;
			end else if (word_done) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take && rec_valid) begin
			cur_q <= rec;
		end
	end

endmodule

>>> hw/rtl/led_engine_program_builder_core.sv
// Top level of the LED engine program builder.
//
//  Channel  | Handshake        | Payload
//  ---------+------------------+----------------------------------------------------
//  request  | push / full      | mode, start_level, end_level, ramp_time, on_time,
//           |                  | period, brightness
//  words    | empty / pop      | program_word, word_index, last, rejected
//
// A blink or rejected request is offered to the queue in the cycle after it is taken;
// a ramp request holds the front end while the divider retires its 18-bit quotient
// three bits per cycle. The back end then presents one word per cycle while pop is
// held, so a program is one, four or five words long. The record queue lets the
// divider work on the next request while words are still being taken.
// Reset clears all control state asynchronously; a stalled pop holds the word.
module led_engine_program_builder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [7:0]  start_level,
	input  logic [7:0]  end_level,
	input  logic [15:0] ramp_time,
	input  logic [15:0] on_time,
	input  logic [15:0] period,
	input  logic [7:0]  brightness,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] program_word,
	output logic [2:0]  word_index,
	output logic        last,
	output logic        rejected
);
	import lepb_pkg::*;

	prog_rec_t front_rec;
	prog_rec_t queue_rec;
	logic      front_valid;
	logic      queue_ready;
	logic      queue_valid;
	logic      back_take;

	// Request intake and divider.
	lepb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.start_level(start_level),
		.end_level  (end_level),
		.ramp_time  (ramp_time),
		.on_time    (on_time),
		.period     (period),
		.brightness (brightness),
		.rec_valid  (front_valid),
		.rec        (front_rec),
		.rec_ready  (queue_ready)
	);

	// Record queue between the two halves.
	lepb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_rec  (front_rec),
		.wr_ready(queue_ready),
		.rd_en   (back_take),
		.rd_rec  (queue_rec),
		.rd_valid(queue_valid)
	);

	// Word emitter.
	lepb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_valid   (queue_valid),
		.rec         (queue_rec),
		.rec_take    (back_take),
		.empty       (empty),
		.pop         (pop),
		.program_word(program_word),
		.word_index  (word_index),
		.last        (last),
		.rejected    (rejected)
	);

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the LED engine program builder core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lepb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int STALL_AFTER  = 150;
	localparam int STALL_CYCLES = 300;
	localparam int IDLE_PERCENT = 16;

	// One program request as offered on the input side.
	typedef struct {
		logic        mode;
		logic [7:0]  start_level;
		logic [7:0]  end_level;
		logic [15:0] ramp_time;
		logic [15:0] on_time;
		logic [15:0] period;
		logic [7:0]  brightness;
	} request_t;

	// One instruction word as it should leave the block.
	typedef struct {
		logic [15:0] word;
		logic [2:0]  index;
		logic        last;
		logic        rejected;
	} prog_word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        mode = 1'b0;
	logic [7:0]  start_level = '0;
	logic [7:0]  end_level = '0;
	logic [15:0] ramp_time = '0;
	logic [15:0] on_time = '0;
	logic [15:0] period = '0;
	logic [7:0]  brightness = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] program_word;
	logic [2:0]  word_index;
	logic        last;
	logic        rejected;

	request_t   pending_requests[$];
	request_t   offered_request;
	prog_word_t expected_words[$];
	prog_word_t head_word;
	int         error_count = 0;
	int         words_taken = 0;
	int         stall_left = 0;
	bit         stall_done = 1'b0;
	bit         steady = 1'b0;
	int         cycle_count = 0;

	led_engine_program_builder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.start_level  (start_level),
		.end_level    (end_level),
		.ramp_time    (ramp_time),
		.on_time      (on_time),
		.period       (period),
		.brightness   (brightness),
		.empty        (empty),
		.pop          (pop),
		.program_word (program_word),
		.word_index   (word_index),
		.last         (last),
		.rejected     (rejected)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Returns {prescale, step} for a raw 16-bit engine time.
	function automatic logic [6:0] step_code(input logic [15:0] raw);
		int unsigned t;
		logic        pre;
		t = 32'(raw);
		pre = 1'b0;
		if (t > 63) begin
			t = t / 32;
			pre = 1'b1;
		end
		if (t == 0) begin
			t = 1;
		end else if (t > 63) begin
			t = 63;
		end
		return {pre, t[5:0]};
	endfunction

	// Works out the instruction words of one request and queues them.
	function automatic void build_program(input request_t r);
		prog_kind_t  kind;
		logic        down;
		logic [7:0]  diff;
		int unsigned quotient;
		logic [15:0] on_scaled;
		logic [15:0] off_gap;
		logic [15:0] off_scaled;
		logic [6:0]  code;
		logic [15:0] words[5];
		int          count;
		kind = r.mode ? KIND_BLINK :
			(r.start_level == r.end_level) ? KIND_REJECT : KIND_RAMP;
		count = 0;
		case (kind)
			KIND_REJECT: begin
				expected_words.push_back('{16'h0000, IDX_LAST_REJECT, 1'b1, 1'b1});
			end
			KIND_RAMP: begin
				down = r.end_level < r.start_level;
				diff = down ? r.start_level - r.end_level : r.end_level - r.start_level;
				quotient = (32'(r.ramp_time) * 2) / 32'(diff);
				code = step_code(quotient[15:0]);
				words[0] = OP_SET_PWM | {8'h00, r.start_level};
				words[1] = {1'b0, code[6], code[5:0], down, diff[7:1]};
				words[2] = OP_LOOP;
				words[3] = OP_END;
				count = 4;
			end
			default: begin
				on_scaled = {r.on_time[14:0], 1'b0};
				off_gap = r.period - r.on_time;
				off_scaled = {off_gap[14:0], 1'b0};
				words[0] = OP_SET_PWM | {8'h00, r.brightness};
				code = step_code(on_scaled);
				words[1] = {1'b0, code[6], code[5:0], 8'h00};
				words[2] = OP_SET_PWM;
				code = step_code(off_scaled);
				words[3] = {1'b0, code[6], code[5:0], 8'h00};
				words[4] = OP_GO_START;
				count = 5;
			end
		endcase
		for (int k = 0; k < count; k++) begin
			expected_words.push_back('{words[k], 3'(k), k == count - 1, 1'b0});
		end
	endfunction

	// Ramp request with random content in the fields it ignores.
	function automatic request_t ramp_request(input logic [7:0] from_level,
		input logic [7:0] to_level, input logic [15:0] duration);
		request_t r;
		r.mode = 1'b0;
		r.start_level = from_level;
		r.end_level = to_level;
		r.ramp_time = duration;
		r.on_time = 16'($urandom);
		r.period = 16'($urandom);
		r.brightness = 8'($urandom);
		return r;
	endfunction

	// Blink request with random content in the fields it ignores.
	function automatic request_t blink_request(input logic [7:0] level,
		input logic [15:0] on_len, input logic [15:0] full_len);
		request_t r;
		r.mode = 1'b1;
		r.start_level = 8'($urandom);
		r.end_level = 8'($urandom);
		r.ramp_time = 16'($urandom);
		r.on_time = on_len;
		r.period = full_len;
		r.brightness = level;
		return r;
	endfunction

	// Random request, biased toward rejects, short steps and wrapped periods.
	function automatic request_t random_request();
		request_t r;
		r.mode = 1'($urandom_range(0, 1));
		r.start_level = 8'($urandom);
		r.end_level = 8'($urandom);
		r.ramp_time = 16'($urandom);
		r.on_time = 16'($urandom);
		r.period = 16'($urandom);
		r.brightness = 8'($urandom);
		case ($urandom_range(0, 9))
			0: r.end_level = r.start_level;
			1, 2: r.ramp_time = 16'($urandom_range(0, 200));
			3: r.end_level = r.start_level + 8'($urandom_range(1, 3));
			4: begin
				r.on_time = 16'($urandom_range(0, 40));
				r.period = r.on_time + 16'($urandom_range(0, 40));
			end
			5: r.period = 16'($urandom_range(0, r.on_time));
			default: ;
		endcase
		return r;
	endfunction

	// Compares one output field and counts a mismatch.
	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	// Waits until every request is taken and every word has come back.
	task automatic wait_until_drained();
		while (pending_requests.size() != 0 || push || expected_words.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Request driver: offers queued requests and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			mode <= 1'b0;
			start_level <= '0;
			end_level <= '0;
			ramp_time <= '0;
			on_time <= '0;
			period <= '0;
			brightness <= '0;
		end else begin
			if (push && !full) begin
				build_program(offered_request);
			end
			if (!push || !full) begin
				if (pending_requests.size() != 0 &&
					(steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
					offered_request = pending_requests.pop_front();
					push <= 1'b1;
					mode <= offered_request.mode;
					start_level <= offered_request.start_level;
					end_level <= offered_request.end_level;
					ramp_time <= offered_request.ramp_time;
					on_time <= offered_request.on_time;
					period <= offered_request.period;
					brightness <= offered_request.brightness;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Word monitor: checks each taken word and decides when to pop.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				words_taken++;
				if (expected_words.size() == 0) begin
					$error("unexpected item: program_word 0x%0h, word_index %0d",
						program_word, word_index);
					error_count++;
				end else begin
					head_word = expected_words.pop_front();
					check_field("program_word", 32'(head_word.word), 32'(program_word));
					check_field("word_index", 32'(head_word.index), 32'(word_index));
					check_field("last", 32'(head_word.last), 32'(last));
					check_field("rejected", 32'(head_word.rejected), 32'(rejected));
				end
			end
			// One long hold-off lets the block fill up and push back on requests.
			if (stall_left != 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!stall_done && words_taken >= STALL_AFTER) begin
				stall_done = 1'b1;
				stall_left = STALL_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= steady || $urandom_range(0, 99) >= IDLE_PERCENT;
			end
		end
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Reset, then directed and random request phases.
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests: field extremes, rejects, clamping and wrapping.
		pending_requests.push_back(ramp_request(8'd0, 8'd255, 16'd0));
		pending_requests.push_back(ramp_request(8'd255, 8'd0, 16'hFFFF));
		pending_requests.push_back(ramp_request(8'd0, 8'd1, 16'hFFFF));
		pending_requests.push_back(ramp_request(8'd0, 8'd0, 16'd500));
		pending_requests.push_back(ramp_request(8'd255, 8'd255, 16'hFFFF));
		pending_requests.push_back(ramp_request(8'd100, 8'd100, 16'd0));
		pending_requests.push_back(ramp_request(8'd10, 8'd20, 16'd31));
		pending_requests.push_back(ramp_request(8'd1, 8'd0, 16'd32));
		pending_requests.push_back(ramp_request(8'd0, 8'd200, 16'd3));
		pending_requests.push_back(ramp_request(8'd0, 8'd1, 16'd1000));
		pending_requests.push_back(ramp_request(8'd0, 8'd1, 16'd1024));
		// Quotient of exactly 65536 truncates to zero and becomes one.
		pending_requests.push_back(ramp_request(8'd0, 8'd1, 16'd32768));
		pending_requests.push_back(ramp_request(8'd200, 8'd73, 16'hAAAA));
		pending_requests.push_back(blink_request(8'd0, 16'd0, 16'd0));
		pending_requests.push_back(blink_request(8'd255, 16'hFFFF, 16'hFFFF));
		pending_requests.push_back(blink_request(8'd85, 16'd31, 16'd62));
		pending_requests.push_back(blink_request(8'd170, 16'd32, 16'd100));
		// Periods shorter than the on time wrap before scaling.
		pending_requests.push_back(blink_request(8'd1, 16'd100, 16'd50));
		pending_requests.push_back(blink_request(8'd128, 16'd32768, 16'd0));
		pending_requests.push_back(blink_request(8'd127, 16'd0, 16'hFFFF));
		pending_requests.push_back(blink_request(8'd254, 16'h5555, 16'hAAAA));
		wait_until_drained();

		// Random traffic with idling on both sides and the long hold-off.
		for (int i = 0; i < 200; i++) begin
			pending_requests.push_back(random_request());
		end
		wait_until_drained();

		// Back-to-back stretch with no idling.
		steady = 1'b1;
		for (int i = 0; i < 100; i++) begin
			pending_requests.push_back(random_request());
		end
		wait_until_drained();
		steady = 1'b0;

		for (int i = 0; i < 200; i++) begin
			pending_requests.push_back(random_request());
		end
		wait_until_drained();

		// Let any stray word show up before the verdict.
		repeat (20) @(negedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
